### rtl/thermistor_voltage_to_temperature_macros.svh
// Assertion macros shared by the thermistor converter RTL.
`ifndef THERMISTOR_VOLTAGE_TO_TEMPERATURE_MACROS_SVH
`define THERMISTOR_VOLTAGE_TO_TEMPERATURE_MACROS_SVH

`ifndef SYNTHESIS
`define TVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TVT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TVT_ASSERT(lbl, prop, msg)
`define TVT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### rtl/tvt_pkg.sv
// Shared constants, curve tables and stage types of the thermistor converter.
`default_nettype none

package tvt_pkg;

  localparam int ROM_POINTS            = 32;
  localparam int ROM_IDX_W             = 5;
  localparam int DEFAULT_TABLE_ENTRIES = 32;

  localparam int MV_W        = 12;
  localparam int TEMP_W      = 12;
  localparam int SPAN_W      = 7;
  localparam int DT_W        = 7;
  localparam int NUM_W       = 13;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int Q_W         = 7;
  localparam int TDATA_W     = 16;

  localparam logic signed [TEMP_W-1:0] OOR_TENTHS = -12'sd10;
  localparam logic signed [TEMP_W-1:0] MIN_TENTHS = -12'sd400;
  localparam logic signed [TEMP_W-1:0] MAX_TENTHS = 12'sd1200;

  localparam logic [MV_W-1:0] CURVE_MV [ROM_POINTS] = '{
    12'd2440, 12'd2420, 12'd2400, 12'd2380, 12'd2350, 12'd2320, 12'd2270, 12'd2230,
    12'd2170, 12'd2110, 12'd2050, 12'd1990, 12'd1920, 12'd1860, 12'd1800, 12'd1740,
    12'd1680, 12'd1630, 12'd1590, 12'd1550, 12'd1510, 12'd1480, 12'd1450, 12'd1430,
    12'd1400, 12'd1380, 12'd1370, 12'd1350, 12'd1340, 12'd1330, 12'd1320, 12'd1300
  };

  localparam logic signed [TEMP_W-1:0] CURVE_TENTHS [ROM_POINTS] = '{
    -12'sd400, -12'sd350, -12'sd300, -12'sd250, -12'sd200, -12'sd150, -12'sd100, -12'sd50,
    12'sd0, 12'sd50, 12'sd100, 12'sd150, 12'sd200, 12'sd250, 12'sd300, 12'sd350,
    12'sd400, 12'sd450, 12'sd500, 12'sd550, 12'sd600, 12'sd650, 12'sd700, 12'sd750,
    12'sd800, 12'sd850, 12'sd900, 12'sd950, 12'sd1000, 12'sd1050, 12'sd1100, 12'sd1200
  };

  // Rounded-up reciprocal of each segment span, scaled by 2**RECIP_SHIFT.
  // With numerators below 2**NUM_W the scaled product gives the exact floor.
  localparam logic [RECIP_W-1:0] SEG_RECIP [ROM_POINTS] = '{
    17'd52429, 17'd52429, 17'd52429, 17'd34953, 17'd34953, 17'd20972, 17'd26215, 17'd17477,
    17'd17477, 17'd17477, 17'd17477, 17'd14980, 17'd17477, 17'd17477, 17'd17477, 17'd17477,
    17'd20972, 17'd26215, 17'd26215, 17'd26215, 17'd34953, 17'd34953, 17'd52429, 17'd34953,
    17'd52429, 17'd104858, 17'd52429, 17'd104858, 17'd104858, 17'd104858, 17'd52429, 17'd0
  };

  typedef struct packed {
    logic [MV_W-1:0]      mv;
    logic [ROM_IDX_W-1:0] seg;
    logic                 hit;
  } seg_t;

  typedef struct packed {
    logic [NUM_W-1:0]          num;
    logic [RECIP_W-1:0]        recip;
    logic signed [TEMP_W-1:0]  t0;
    logic                      hit;
  } prod_t;

  typedef struct packed {
    logic [Q_W-1:0]            q;
    logic signed [TEMP_W-1:0]  t0;
    logic                      hit;
  } interp_t;

endpackage

`default_nettype wire

### rtl/tvt_search.sv
// Segment search stage: compares the voltage against every breakpoint at once.
`default_nettype none

module tvt_search
  import tvt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output      logic            ready_o,
  input  wire logic [MV_W-1:0] mv_i,
  output      logic            valid_o,
  input  wire logic            ready_i,
  output      seg_t            seg_o
);

  localparam int POINTS = (TABLE_ENTRIES < ROM_POINTS) ? TABLE_ENTRIES : ROM_POINTS;

  logic [ROM_POINTS-2:0] match;
  seg_t                  seg_d;
  seg_t                  seg_q;
  logic                  valid_q;

  always_comb begin
    for (int i = 0; i < ROM_POINTS - 1; i++) begin
      match[i] = (i + 1 < POINTS) && (mv_i <= CURVE_MV[i]) && (mv_i >= CURVE_MV[i+1]);
    end
  end

  always_comb begin
    seg_d.mv  = mv_i;
    seg_d.seg = '0;
    seg_d.hit = |match;
    for (int i = ROM_POINTS - 2; i >= 0; i--) begin
      if (match[i]) begin
        seg_d.seg = ROM_IDX_W'(i);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      seg_q <= seg_d;
    end
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;

endmodule

`default_nettype wire

### rtl/tvt_interp.sv
// Interpolation stages: slope product, then scaled reciprocal multiply.
`default_nettype none

module tvt_interp
  import tvt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output      logic ready_o,
  input  wire seg_t seg_i,
  output      logic valid_o,
  input  wire logic ready_i,
  output      interp_t res_o
);

  logic [ROM_IDX_W-1:0]     seg_nx;
  logic [MV_W-1:0]          d_full;
  logic signed [TEMP_W-1:0] dt_full;
  logic [SPAN_W-1:0]        d_w;
  logic [DT_W-1:0]          dt_w;
  prod_t                    prod_d;
  prod_t                    prod_q;
  logic                     prod_valid_q;
  logic                     prod_ready;
  logic [PROD_W-1:0]        scaled;
  interp_t                  res_d;
  interp_t                  res_q;
  logic                     res_valid_q;

  assign seg_nx  = ROM_IDX_W'(seg_i.seg + 1'b1);
  assign d_full  = CURVE_MV[seg_i.seg] - seg_i.mv;
  assign dt_full = CURVE_TENTHS[seg_nx] - CURVE_TENTHS[seg_i.seg];
  assign d_w     = d_full[SPAN_W-1:0];
  assign dt_w    = dt_full[DT_W-1:0];

  always_comb begin
    prod_d.num   = {{(NUM_W-SPAN_W){1'b0}}, d_w} * {{(NUM_W-DT_W){1'b0}}, dt_w};
    prod_d.recip = SEG_RECIP[seg_i.seg];
    prod_d.t0    = CURVE_TENTHS[seg_i.seg];
    prod_d.hit   = seg_i.hit;
  end

  assign ready_o = !prod_valid_q || prod_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (ready_o) begin
      prod_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
    end
  end

  assign scaled = {{(PROD_W-NUM_W){1'b0}}, prod_q.num}
                * {{(PROD_W-RECIP_W){1'b0}}, prod_q.recip};

  always_comb begin
    res_d.q   = scaled[RECIP_SHIFT +: Q_W];
    res_d.t0  = prod_q.t0;
    res_d.hit = prod_q.hit;
  end

  assign prod_ready = !res_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (prod_ready) begin
      res_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_valid_q && prod_ready) begin
      res_q <= res_d;
    end
  end

  assign valid_o = res_valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

### rtl/thermistor_voltage_to_temperature.sv
// Each input transaction passes through four register stages (segment search, slope
// product, reciprocal multiply, sum) before its result can be taken.
// Throughput: one transaction per cycle while m_axis_tready_i is high; each stage holds
// one item and moves on whenever the stage after it has room, so a stall loses and repeats nothing.
// Reset: the asynchronous reset clears the valid bit of every stage; no table is cleared.
`default_nettype none
`include "thermistor_voltage_to_temperature_macros.svh"

module thermistor_voltage_to_temperature
  import tvt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output      logic               s_axis_tready_o,
  input  wire logic [TDATA_W-1:0] s_axis_tdata_i,  // [11:0] voltage_mv
  output      logic               m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output      logic [TDATA_W-1:0] m_axis_tdata_o,  // [11:0] temperature_tenths
  output      logic               m_axis_tuser_o   // [0] out_of_range
);

  logic                     seg_valid;
  logic                     seg_ready;
  seg_t                     seg;
  logic                     res_valid;
  logic                     res_ready;
  interp_t                  res;
  logic signed [TEMP_W-1:0] temp_d;
  logic signed [TEMP_W-1:0] temp_q;
  logic                     oor_q;
  logic                     out_valid_q;

  tvt_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid_i),
    .ready_o(s_axis_tready_o),
    .mv_i   (s_axis_tdata_i[MV_W-1:0]),
    .valid_o(seg_valid),
    .ready_i(seg_ready),
    .seg_o  (seg)
  );

  tvt_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(seg_valid),
    .ready_o(seg_ready),
    .seg_i  (seg),
    .valid_o(res_valid),
    .ready_i(res_ready),
    .res_o  (res)
  );

  assign temp_d = res.hit ? (res.t0 + $signed({{(TEMP_W-Q_W){1'b0}}, res.q})) : OOR_TENTHS;

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      temp_q <= temp_d;
      oor_q  <= !res.hit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(TDATA_W-TEMP_W){1'b0}}, temp_q};
  assign m_axis_tuser_o  = oor_q;

  `TVT_ASSERT(a_oor_temp, m_axis_tvalid_o && m_axis_tuser_o |-> temp_q == OOR_TENTHS, "Out-of-range result must read minus one degree.")
  `TVT_ASSERT(a_temp_bounds, m_axis_tvalid_o && !m_axis_tuser_o |-> temp_q >= MIN_TENTHS && temp_q <= MAX_TENTHS, "In-range temperature left the curve bounds.")
  `TVT_ASSERT(a_interp_bounds, res_valid && res.hit |-> res.q <= Q_W'(100), "Interpolation step exceeds the widest segment.")
  `TVT_ASSERT_RST(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "Output valid after a reset cycle.")

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the thermistor converter, predicting each reading from its own curve.
module tb;
  import tvt_pkg::*;

  typedef struct packed {
    logic signed [TEMP_W-1:0] tenths;
    logic                     out_of_range;
  } reading_t;

  localparam int CURVE_POINTS = 32;
  localparam int CURVE_MV_LO  = 1300;
  localparam int CURVE_MV_HI  = 2440;
  localparam int MV_MAX       = 4095;
  localparam int IDLE_PERCENT = 15;

  localparam int BEND_MV [CURVE_POINTS] = '{
    2440, 2420, 2400, 2380, 2350, 2320, 2270, 2230,
    2170, 2110, 2050, 1990, 1920, 1860, 1800, 1740,
    1680, 1630, 1590, 1550, 1510, 1480, 1450, 1430,
    1400, 1380, 1370, 1350, 1340, 1330, 1320, 1300
  };
  localparam int BEND_TENTHS [CURVE_POINTS] = '{
    -400, -350, -300, -250, -200, -150, -100, -50,
       0,   50,  100,  150,  200,  250,  300,  350,
     400,  450,  500,  550,  600,  650,  700,  750,
     800,  850,  900,  950, 1000, 1050, 1100, 1200
  };

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [TDATA_W-1:0] s_axis_tdata_i  = '0;  // [11:0] voltage_mv
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;       // [11:0] temperature_tenths
  logic               m_axis_tuser_o;       // [0] out_of_range

  reading_t pending_readings[$];
  int       mismatches = 0;
  bit       steady     = 1'b0;

  thermistor_voltage_to_temperature uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic reading_t convert_voltage(input logic [MV_W-1:0] mv);
    reading_t r;
    int       v;
    int       span;
    r.tenths       = OOR_TENTHS;
    r.out_of_range = 1'b1;
    v              = int'(mv);
    for (int i = 0; i + 1 < CURVE_POINTS; i++) begin
      if (r.out_of_range && v <= BEND_MV[i] && v >= BEND_MV[i+1]) begin
        span           = BEND_MV[i] - BEND_MV[i+1];
        r.tenths       = TEMP_W'(BEND_TENTHS[i] +
                         ((BEND_TENTHS[i+1] - BEND_TENTHS[i]) * (BEND_MV[i] - v)) / span);
        r.out_of_range = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic send_voltage(input int mv);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= TDATA_W'(MV_W'(mv));
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_readings.push_back(convert_voltage(MV_W'(mv)));
  endtask

  task automatic drain_readings();
    s_axis_tvalid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected transaction: temperature_tenths %0d, out_of_range %0b",
               $signed(m_axis_tdata_o[TEMP_W-1:0]), m_axis_tuser_o);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata_o[TEMP_W-1:0] !== want.tenths) begin
          $error("temperature_tenths: expected %0d, got %0d", want.tenths,
                 $signed(m_axis_tdata_o[TEMP_W-1:0]));
          mismatches++;
        end
        if (m_axis_tuser_o !== want.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", want.out_of_range, m_axis_tuser_o);
          mismatches++;
        end
      end
    end
  end

  // Curve ends, their neighbors, all-zero and all-one codes, and a few exact breakpoints.
  task automatic test_edges();
    int probes[$] = '{0, MV_MAX, 3300, 2441, 2440, 2439, 2435, 2048, 2270, 2000,
                      1400, 1365, 1320, 1310, 1301, 1300, 1299, 1024, 2047};
    foreach (probes[k]) send_voltage(probes[k]);
  endtask

  task automatic test_curve_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      send_voltage($urandom_range(CURVE_MV_LO, CURVE_MV_HI));
      else if (pick < 85) send_voltage(BEND_MV[$urandom_range(0, CURVE_POINTS - 1)]);
      else                send_voltage($urandom_range(0, MV_MAX));
    end
  endtask

  task automatic test_back_to_back(input int count);
    steady = 1'b1;
    test_curve_random(count);
    steady = 1'b0;
  endtask

  task automatic test_full_range(input int count);
    for (int n = 0; n < count; n++) send_voltage($urandom_range(0, MV_MAX));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    drain_readings();
    test_curve_random(500);
    test_back_to_back(200);
    test_full_range(230);
    drain_readings();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/tvt_pkg.sv
rtl/tvt_search.sv
rtl/tvt_interp.sv
rtl/thermistor_voltage_to_temperature.sv
sim/tb.sv
